FILE: sv/float_lexeme_scanner_unit_macros.svh
// assertion macros used by the scanner top module
`ifndef FLOAT_LEXEME_SCANNER_UNIT_MACROS_SVH
`define FLOAT_LEXEME_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fls_pkg.sv
`timescale 1ns / 1ps

package fls_pkg;

    typedef enum logic [3:0] {
        PH_FIN      = 4'd0,
        PH_SIGN     = 4'd1,
        PH_LEAD     = 4'd2,
        PH_INF      = 4'd3,
        PH_NANW     = 4'd4,
        PH_NANPAREN = 4'd5,
        PH_NANBODY  = 4'd6,
        PH_ZEROX    = 4'd7,
        PH_INT      = 4'd8,
        PH_DOT      = 4'd9,
        PH_FRAC     = 4'd10,
        PH_EXPMARK  = 4'd11,
        PH_EXPSIGN  = 4'd12,
        PH_EXPDIG   = 4'd13
    } phase_t;

    localparam int CHAR_W  = 21;
    localparam int WIDTH_W = 16;
    localparam int POS_W   = 4;

    localparam logic [POS_W-1:0] INF_LEN = 4'd8;
    localparam logic [POS_W-1:0] NAN_LEN = 4'd3;
    localparam logic [WIDTH_W-1:0] LEN_MAX = 16'hFFFF;

    // ascii codes, 7 bits
    localparam logic [6:0] CH_PLUS   = 7'h2B;
    localparam logic [6:0] CH_MINUS  = 7'h2D;
    localparam logic [6:0] CH_DOT    = 7'h2E;
    localparam logic [6:0] CH_0      = 7'h30;
    localparam logic [6:0] CH_9      = 7'h39;
    localparam logic [6:0] CH_LPAREN = 7'h28;
    localparam logic [6:0] CH_RPAREN = 7'h29;
    localparam logic [6:0] CH_UNDER  = 7'h5F;
    localparam logic [6:0] CH_UA     = 7'h41;
    localparam logic [6:0] CH_UZ     = 7'h5A;
    localparam logic [6:0] CH_LA     = 7'h61;
    localparam logic [6:0] CH_LF     = 7'h66;
    localparam logic [6:0] CH_LZ     = 7'h7A;
    localparam logic [6:0] CH_LE     = 7'h65;
    localparam logic [6:0] CH_LI     = 7'h69;
    localparam logic [6:0] CH_LN     = 7'h6E;
    localparam logic [6:0] CH_LP     = 7'h70;
    localparam logic [6:0] CH_LX     = 7'h78;
    localparam logic [6:0] CASE_GAP  = 7'h20;

    typedef struct packed {
        logic       ascii;
        logic [6:0] fold;
        logic       is_eos;
        logic       is_sign;
        logic       is_dec;
        logic       is_hex_alpha;
        logic       is_alpha;
        logic       is_under;
        logic       is_lparen;
        logic       is_rparen;
        logic       is_dot;
        logic       is_zero;
        logic       is_x;
        logic       is_e;
        logic       is_p;
        logic       is_i;
        logic       is_n;
    } char_class_t;

    typedef struct packed {
        phase_t             phase;
        logic [POS_W-1:0]   word_pos;
        logic               hex_mode;
        logic [WIDTH_W-1:0] chars_left;
        logic               no_limit;
        logic [WIDTH_W-1:0] taken_count;
    } scan_state_t;

    typedef struct packed {
        logic               taken;
        logic               finished;
        logic [WIDTH_W-1:0] token_length;
    } scan_result_t;

    // letters of "infinity", lower case
    function automatic logic [6:0] inf_letter(input logic [2:0] idx);
        logic [6:0] r;
        case (idx)
            3'd0:    r = 7'h69;
            3'd1:    r = 7'h6E;
            3'd2:    r = 7'h66;
            3'd3:    r = 7'h69;
            3'd4:    r = 7'h6E;
            3'd5:    r = 7'h69;
            3'd6:    r = 7'h74;
            default: r = 7'h79;
        endcase
        return r;
    endfunction

    // letters of "nan", lower case
    function automatic logic [6:0] nan_letter(input logic [1:0] idx);
        logic [6:0] r;
        case (idx)
            2'd0:    r = 7'h6E;
            2'd1:    r = 7'h61;
            2'd2:    r = 7'h6E;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/fls_if.sv
`timescale 1ns / 1ps

interface fls_in_if;
    import fls_pkg::*;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic [WIDTH_W-1:0] max_width;
    logic [CHAR_W-1:0]  char_code;

    modport source (output valid, start_req, max_width, char_code, input ready);
    modport sink   (input valid, start_req, max_width, char_code, output ready);
endinterface

interface fls_out_if;
    import fls_pkg::*;
    logic               valid;
    logic               ready;
    logic               taken;
    logic               finished;
    logic [WIDTH_W-1:0] token_length;

    modport source (output valid, taken, finished, token_length, input ready);
    modport sink   (input valid, taken, finished, token_length, output ready);
endinterface

FILE: sv/fls_char_class.sv
`timescale 1ns / 1ps

module fls_char_class
    import fls_pkg::*;
(
    input  logic [CHAR_W-1:0] char_code,
    output char_class_t       cls
);

    logic       ascii;
    logic [6:0] a;
    logic [6:0] fold;

    assign ascii = (char_code[CHAR_W-1:7] == '0);
    assign a     = char_code[6:0];

    always_comb
    begin
        if (a inside {[CH_UA:CH_UZ]})
        begin
            fold = a + CASE_GAP;
        end
        else
        begin
            fold = a;
        end
    end

    always_comb
    begin
        cls.ascii        = ascii;
        cls.fold         = fold;
        cls.is_eos       = (char_code == '0);
        cls.is_sign      = ascii && (a == CH_PLUS || a == CH_MINUS);
        cls.is_dec       = ascii && (a inside {[CH_0:CH_9]});
        cls.is_hex_alpha = ascii && (fold inside {[CH_LA:CH_LF]});
        cls.is_alpha     = ascii && (fold inside {[CH_LA:CH_LZ]});
        cls.is_under     = ascii && (a == CH_UNDER);
        cls.is_lparen    = ascii && (a == CH_LPAREN);
        cls.is_rparen    = ascii && (a == CH_RPAREN);
        cls.is_dot       = ascii && (a == CH_DOT);
        cls.is_zero      = ascii && (a == CH_0);
        cls.is_x         = ascii && (fold == CH_LX);
        cls.is_e         = ascii && (fold == CH_LE);
        cls.is_p         = ascii && (fold == CH_LP);
        cls.is_i         = ascii && (fold == CH_LI);
        cls.is_n         = ascii && (fold == CH_LN);
    end

endmodule

FILE: sv/fls_step.sv
`timescale 1ns / 1ps

module fls_step
    import fls_pkg::*;
(
    input  scan_state_t        cur,
    input  logic               start_req,
    input  logic [WIDTH_W-1:0] max_width,
    input  char_class_t        cls,
    output scan_state_t        nxt_state,
    output scan_result_t       res
);

    scan_state_t        eff;
    logic               acc;
    phase_t             nxt;
    logic [POS_W-1:0]   wp;
    logic               hx;
    logic               mant;
    logic               go_lead;
    logic               go_int;
    logic               go_dot;
    logic               go_exp;
    logic               go_paren;
    logic               go_expdig;
    logic [WIDTH_W-1:0] left_new;

    always_comb
    begin
        eff = cur;
        if (start_req)
        begin
            eff.phase       = PH_SIGN;
            eff.word_pos    = '0;
            eff.hex_mode    = 1'b0;
            eff.chars_left  = max_width;
            eff.no_limit    = (max_width == '0);
            eff.taken_count = '0;
        end
        // end of string or exhausted width kills the token before judging
        if (cls.is_eos || (!eff.no_limit && eff.chars_left == '0))
        begin
            eff.phase = PH_FIN;
        end

        acc       = 1'b0;
        nxt       = PH_FIN;
        wp        = eff.word_pos;
        hx        = eff.hex_mode;
        mant      = cls.is_dec || (eff.hex_mode && cls.is_hex_alpha);
        go_lead   = 1'b0;
        go_int    = 1'b0;
        go_dot    = 1'b0;
        go_exp    = 1'b0;
        go_paren  = 1'b0;
        go_expdig = 1'b0;

        case (eff.phase)
            PH_SIGN:
            begin
                if (cls.is_sign)
                begin
                    acc = 1'b1;
                    nxt = PH_LEAD;
                end
                else
                begin
                    go_lead = 1'b1;
                end
            end
            PH_LEAD:
            begin
                go_lead = 1'b1;
            end
            PH_INF:
            begin
                if (eff.word_pos < INF_LEN && cls.ascii
                    && cls.fold == inf_letter(eff.word_pos[2:0]))
                begin
                    acc = 1'b1;
                    wp  = eff.word_pos + 4'd1;
                    nxt = (wp == INF_LEN) ? PH_FIN : PH_INF;
                end
            end
            PH_NANW:
            begin
                if (eff.word_pos < NAN_LEN && cls.ascii
                    && cls.fold == nan_letter(eff.word_pos[1:0]))
                begin
                    acc = 1'b1;
                    wp  = eff.word_pos + 4'd1;
                    nxt = PH_NANW;
                end
                else
                begin
                    go_paren = 1'b1;
                end
            end
            PH_NANPAREN:
            begin
                go_paren = 1'b1;
            end
            PH_NANBODY:
            begin
                if (cls.is_dec || cls.is_alpha || cls.is_under)
                begin
                    acc = 1'b1;
                    nxt = PH_NANBODY;
                end
                else if (cls.is_rparen)
                begin
                    acc = 1'b1;
                    nxt = PH_FIN;
                end
            end
            PH_ZEROX:
            begin
                if (cls.is_x)
                begin
                    acc = 1'b1;
                    hx  = 1'b1;
                    nxt = PH_INT;
                end
                else
                begin
                    go_int = 1'b1;
                end
            end
            PH_INT:
            begin
                go_int = 1'b1;
            end
            PH_DOT:
            begin
                go_dot = 1'b1;
            end
            PH_FRAC:
            begin
                if (mant)
                begin
                    acc = 1'b1;
                    nxt = PH_FRAC;
                end
                else
                begin
                    go_exp = 1'b1;
                end
            end
            PH_EXPMARK:
            begin
                go_exp = 1'b1;
            end
            PH_EXPSIGN:
            begin
                if (cls.is_sign)
                begin
                    acc = 1'b1;
                    nxt = PH_EXPDIG;
                end
                else
                begin
                    go_expdig = 1'b1;
                end
            end
            PH_EXPDIG:
            begin
                go_expdig = 1'b1;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase

        // fall-through chain of the grammar, in order
        if (go_lead)
        begin
            if (cls.is_i)
            begin
                acc = 1'b1;
                wp  = 4'd1;
                nxt = PH_INF;
            end
            else if (cls.is_n)
            begin
                acc = 1'b1;
                wp  = 4'd1;
                nxt = PH_NANW;
            end
            else if (cls.is_zero)
            begin
                acc = 1'b1;
                nxt = PH_ZEROX;
            end
            else
            begin
                go_int = 1'b1;
            end
        end
        if (go_int)
        begin
            if (mant)
            begin
                acc = 1'b1;
                nxt = PH_INT;
            end
            else
            begin
                go_dot = 1'b1;
            end
        end
        if (go_dot)
        begin
            if (cls.is_dot)
            begin
                acc = 1'b1;
                nxt = PH_FRAC;
            end
            else
            begin
                go_exp = 1'b1;
            end
        end
        if (go_exp)
        begin
            if (eff.hex_mode ? cls.is_p : cls.is_e)
            begin
                acc = 1'b1;
                nxt = PH_EXPSIGN;
            end
        end
        if (go_paren)
        begin
            if (cls.is_lparen)
            begin
                acc = 1'b1;
                nxt = PH_NANBODY;
            end
        end
        if (go_expdig)
        begin
            if (cls.is_dec)
            begin
                acc = 1'b1;
                nxt = PH_EXPDIG;
            end
        end

        nxt_state = eff;
        left_new  = eff.chars_left;
        if (acc)
        begin
            if (eff.taken_count != LEN_MAX)
            begin
                nxt_state.taken_count = eff.taken_count + 16'd1;
            end
            if (!eff.no_limit && eff.chars_left != '0)
            begin
                left_new = eff.chars_left - 16'd1;
            end
            nxt_state.chars_left = left_new;
            nxt_state.word_pos   = wp;
            nxt_state.hex_mode   = hx;
            nxt_state.phase      = (!eff.no_limit && left_new == '0) ? PH_FIN : nxt;
        end
        else
        begin
            nxt_state.phase = PH_FIN;
        end

        res.taken        = acc;
        res.finished     = (nxt_state.phase == PH_FIN);
        res.token_length = nxt_state.taken_count;
    end

endmodule

FILE: sv/float_lexeme_scanner_unit.sv
`timescale 1ns / 1ps
// channel  | dir | word fields                          | accepted when
// ---------+-----+--------------------------------------+---------------------
// chars    | in  | start_req, max_width, char_code      | valid && ready
// lexemes  | out | taken, finished, token_length        | valid && ready
//
// one character word per cycle sustained while the lexemes side is ready
// the rate is set by the scanner state loop: state update and result load
// happen together when a word moves from the input register to the result register
// reset puts the scanner in the finished phase and empties both registers
// a stalled result register holds its word; one more character waits in the input register

`include "float_lexeme_scanner_unit_macros.svh"

module float_lexeme_scanner_unit
    import fls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fls_in_if.sink     chars,
    fls_out_if.source  lexemes
);

    // input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_start_reg;
    logic [WIDTH_W-1:0] in_width_reg;
    logic [CHAR_W-1:0]  in_char_reg;

    // scanner state
    scan_state_t        state_reg;
    scan_state_t        state_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    scan_result_t       out_reg;

    scan_result_t       step_res;
    char_class_t        cls;
    logic               load_in;
    logic               advance;

    // a word moves forward when the result register is free or drains now
    assign advance       = in_valid_reg && (!out_valid_reg || lexemes.ready);
    assign chars.ready   = !in_valid_reg || advance;
    assign load_in       = chars.valid && chars.ready;

    fls_char_class u_class
    (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    fls_step u_step
    (
        .cur       (state_reg),
        .start_req (in_start_reg),
        .max_width (in_width_reg),
        .cls       (cls),
        .nxt_state (state_next),
        .res       (step_res)
    );

    always_comb
    begin
        if (load_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (lexemes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= PH_FIN;
            state_reg.word_pos    <= '0;
            state_reg.hex_mode    <= 1'b0;
            state_reg.chars_left  <= '0;
            state_reg.no_limit    <= 1'b0;
            state_reg.taken_count <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_start_reg <= chars.start_req;
            in_width_reg <= chars.max_width;
            in_char_reg  <= chars.char_code;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign lexemes.valid        = out_valid_reg;
    assign lexemes.taken        = out_reg.taken;
    assign lexemes.finished     = out_reg.finished;
    assign lexemes.token_length = out_reg.token_length;

    // a word that moves forward always shows up as a result
    `FLS_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg, "result word lost")
    // a rejected character always ends the token
    `FLS_ASSERT_NEXT(a_reject_ends_token, advance && !step_res.taken,
        state_reg.phase == PH_FIN, "token still open after rejection")
    // the finished flag tracks the scanner phase
    `FLS_ASSERT_NEXT(a_finished_matches_phase, advance,
        out_reg.finished == (state_reg.phase == PH_FIN), "finished flag out of step")
    // an open limited token always has width left
    `FLS_ASSERT_NOW(a_width_left, !state_reg.no_limit && state_reg.phase != PH_FIN,
        state_reg.chars_left != '0, "open token with no width left")

endmodule
